/* rtl/bcsh_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcsh_pkg
// Shared constants for the bit crusher with sample-and-hold rate reduction.
// ----------------------------------------------------------------------------
package bcsh_pkg;

  // Rate step field, unsigned Q0.16 with one extra bit for values of 1.0 and up.
  localparam int unsigned STEP_W  = 17;
  // Bit depth field.
  localparam int unsigned DEPTH_W = 5;
  // Phase accumulator, Q2.16. It never exceeds 65535 + 65536.
  localparam int unsigned PHASE_W = 18;
  // Number of fraction bits of the phase.
  localparam int unsigned FRAC_W  = 16;

  // 1.0 as a rate step.
  localparam logic [STEP_W-1:0] STEP_ONE = STEP_W'(1) << FRAC_W;

endpackage

/* rtl/bit_crush_sample_hold.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bit_crush_sample_hold
// Bit-depth and sample-rate reducer for fixed-point audio streams.
// ----------------------------------------------------------------------------
// Each input transaction carries one signed sample (Q1.(SAMPLE_BITS-1)), a
// rate step in Q1.16 and a bit depth. Every input transaction produces exactly
// one output transaction carrying the currently held, requantized sample. The
// block takes one transaction per clock cycle when the output side keeps up.
// The input register loads on acceptance and the output register loads from
// it whenever the output register is empty or its transaction is being taken,
// so a result passes through both registers before it can be taken. A stalled
// output fills the input register and then deasserts s_axis_tready, so no
// transaction is ever lost.
// There are no configuration registers; phase and held value reset to zero.

module bit_crush_sample_hold
  import bcsh_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = 24
) (
  input  logic                      clk,
  input  logic                      rst,
  // Input stream.
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // Fields from bit 0 up: sample, rate_step, bit_depth, zero padding to bytes.
  input  logic [((SAMPLE_BITS+STEP_W+DEPTH_W+7)/8)*8-1:0] s_axis_tdata,
  // Output stream.
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // Fields from bit 0 up: held_sample, zero padding to bytes.
  output logic [((SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata
);

  localparam int unsigned OUT_W   = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int unsigned SHIFT_W = $clog2(SAMPLE_BITS);
  localparam int unsigned DCL_W   = $clog2(SAMPLE_BITS + 1);

  // Most negative sample, -1.0, at the widened precision used for the
  // negative branch of the requantizer.
  localparam logic signed [SAMPLE_BITS+1:0] MIN_WIDE =
    -($signed((SAMPLE_BITS+2)'(1)) <<< (SAMPLE_BITS - 1));

  // Input register. The fields are captured on acceptance.
  logic                          in_valid;
  logic signed [SAMPLE_BITS-1:0] in_sample;
  logic [STEP_W-1:0]             in_step;
  logic [DEPTH_W-1:0]            in_depth;

  // Stream state: phase accumulator and held value. The held value is also
  // the output register's payload, since it only changes when a new result
  // is loaded.
  logic                          out_valid;
  logic [PHASE_W-1:0]            phase_acc;
  logic [PHASE_W-1:0]            phase_acc_next;
  logic signed [SAMPLE_BITS-1:0] held_value;
  logic signed [SAMPLE_BITS-1:0] held_value_next;

  logic                          advance;

  // Requantizer signals.
  logic [DCL_W-1:0]              depth_c;
  logic [SHIFT_W-1:0]            shift;
  logic [SAMPLE_BITS-1:0]        keep;
  logic [SAMPLE_BITS+1:0]        quantum;
  logic signed [SAMPLE_BITS:0]   sample_ext;
  logic [SAMPLE_BITS:0]          magnitude;
  logic signed [SAMPLE_BITS+1:0] neg_wide;
  logic signed [SAMPLE_BITS-1:0] crushed;
  logic [STEP_W-1:0]             step_c;

  // The input register moves into the output stage whenever the output
  // register is empty or its current transaction is being taken.
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = OUT_W'($unsigned(held_value));

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_sample <= $signed(s_axis_tdata[SAMPLE_BITS-1:0]);
      in_step   <= s_axis_tdata[SAMPLE_BITS +: STEP_W];
      in_depth  <= s_axis_tdata[SAMPLE_BITS+STEP_W +: DEPTH_W];
    end
  end

  // Requantize to a quantum of 2^(SAMPLE_BITS - depth) LSBs. Positive samples
  // truncate toward zero; zero and negative samples truncate toward zero and
  // then drop one more quantum, saturating at -1.0.
  always_comb begin
    if (in_depth == '0) begin
      depth_c = DCL_W'(1);
    end else if (32'(in_depth) > SAMPLE_BITS) begin
      depth_c = DCL_W'(SAMPLE_BITS);
    end else begin
      depth_c = DCL_W'(in_depth);
    end
    shift      = SHIFT_W'(SAMPLE_BITS - 32'(depth_c));
    keep       = {SAMPLE_BITS{1'b1}} << shift;
    quantum    = (SAMPLE_BITS+2)'(1) << shift;
    sample_ext = {in_sample[SAMPLE_BITS-1], in_sample};
    magnitude  = $unsigned(-sample_ext);
    neg_wide   = -$signed({1'b0, magnitude & {1'b1, keep}}) - $signed(quantum);
    if (neg_wide < MIN_WIDE) begin
      neg_wide = MIN_WIDE;
    end
    if (!in_sample[SAMPLE_BITS-1] && (in_sample != '0)) begin
      crushed = $signed($unsigned(in_sample) & keep);
    end else begin
      crushed = neg_wide[SAMPLE_BITS-1:0];
    end
  end

  // Sample-and-hold: a phase of 1.0 or more before the update latches the new
  // value, then the phase keeps its fraction and adds the clamped step.
  always_comb begin
    step_c = (in_step > STEP_ONE) ? STEP_ONE : in_step;
    phase_acc_next = PHASE_W'(phase_acc[FRAC_W-1:0]) + PHASE_W'(step_c);
    if (phase_acc[PHASE_W-1:FRAC_W] != '0) begin
      held_value_next = crushed;
    end else begin
      held_value_next = held_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      phase_acc  <= '0;
      held_value <= '0;
    end else begin
      if (advance) begin
        out_valid  <= 1'b1;
        phase_acc  <= phase_acc_next;
        held_value <= held_value_next;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* rtl/bcsh_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcsh_checker
// Port-level checks for the bit crusher, attached to the top level by bind.
// ----------------------------------------------------------------------------
module bcsh_checker
  import bcsh_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = 24
) (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [((SAMPLE_BITS+7)/8)*8-1:0]  m_axis_tdata
);

  // A pending result holds its data until it is taken.
  a_out_stable : assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed while stalled");

  // Reset empties the pipeline.
  a_reset_empty : assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

  // Input back-pressure only ever comes from a stalled output.
  a_ready_cause : assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output stall");

  // A result appearing on an empty output came from an accepted input that passed through the input register.
  a_out_source : assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("result without a matching input");

endmodule

bind bit_crush_sample_hold bcsh_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_bcsh_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
